// ===== src/mlfq_task_scheduler_macros.svh =====
// Assertion macros for the feedback queue scheduler.
`ifndef MLFQ_TASK_SCHEDULER_MACROS_SVH
`define MLFQ_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define MLFQ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define MLFQ_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define MLFQ_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define MLFQ_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ===== src/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types and codes shared by the scheduler controller and datapath.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	// Slot status codes.
	localparam logic [2:0] ST_FREE  = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// Outcome codes of a tick.
	localparam logic [2:0] OUT_NONE     = 3'd0;
	localparam logic [2:0] OUT_CONTINUE = 3'd1;
	localparam logic [2:0] OUT_FINISHED = 3'd2;
	localparam logic [2:0] OUT_TO_IO    = 3'd3;
	localparam logic [2:0] OUT_EXPIRED  = 3'd4;

	localparam int TICK_BITS = 24;
	localparam int BOOST_BITS = 16;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_IO_WALK,
		CS_DISPATCH,
		CS_RUN,
		CS_BOOST,
		CS_RESULT
	} ctl_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic arrive;
		logic io_start;
		logic io_step;
		logic dispatch;
		logic run;
		logic boost_start;
		logic boost_step;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic io_busy;
		logic boost_busy;
	} dp_sts_t;

endpackage

// ===== src/mlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer for one item: an arrival goes straight to the result handoff; a tick
// steps through I/O walk, dispatch, run and boost phases, then the result handoff.
// ----------------------------------------------------------------------------
module mlfq_ctrl
	import mlfq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  logic    in_func,
	input  logic    out_free,
	input  dp_sts_t sts,
	output logic    in_ready,
	output logic    res_valid,
	output dp_cmd_t cmd
);

	ctl_state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_fire) state_d = in_func ? CS_IO_WALK : CS_RESULT;
			end
			CS_IO_WALK: begin
				if (!sts.io_busy) state_d = CS_DISPATCH;
			end
			CS_DISPATCH: state_d = CS_RUN;
			CS_RUN: state_d = CS_BOOST;
			CS_BOOST: begin
				if (!sts.boost_busy) state_d = CS_RESULT;
			end
			CS_RESULT: begin
				if (out_free) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		res_valid = 1'b0;
		in_ready = (state_q == CS_IDLE);
		case (state_q)
			CS_IDLE: begin
				cmd.arrive = in_fire && !in_func;
				cmd.io_start = in_fire && in_func;
			end
			CS_IO_WALK: cmd.io_step = sts.io_busy;
			CS_DISPATCH: cmd.dispatch = 1'b1;
			CS_RUN: begin
				cmd.run = 1'b1;
				cmd.boost_start = 1'b1;
			end
			CS_BOOST: cmd.boost_step = sts.boost_busy;
			CS_RESULT: res_valid = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/mlfq_dp.sv =====
// ----------------------------------------------------------------------------
// mlfq_dp
// Job table, linked lists, running job and tick counters.
// ----------------------------------------------------------------------------
`include "mlfq_task_scheduler_macros.svh"
module mlfq_dp
	import mlfq_pkg::*;
#(
	parameter int MAX_JOBS = 16,
	parameter int NUM_LEVELS = 3,
	parameter int WORK_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	input  logic [3:0]              job_id,
	input  logic [WORK_BITS-1:0]    work,
	input  logic [15:0]             io_done_mask,
	input  logic                    wants_io,
	input  logic [BOOST_BITS-1:0]   boost_period,
	output dp_sts_t                 sts,
	output logic [TICK_BITS-1:0]    r_tick,
	output logic                    r_valid,
	output logic [3:0]              r_job,
	output logic [1:0]              r_level,
	output logic [2:0]              r_outcome,
	output logic                    r_first,
	output logic                    r_boost,
	output logic                    r_err
);

	localparam int SB = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int LB = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int NQ = NUM_LEVELS + 1;
	localparam int QB = $clog2(NQ);
	localparam int SLB = $clog2(1 << (NUM_LEVELS - 1)) + 1;
	localparam logic [QB-1:0] IO_Q = QB'(NUM_LEVELS);

	// Job table.
	logic [2:0]           status_q [MAX_JOBS];
	logic [WORK_BITS-1:0] remain_q [MAX_JOBS];
	logic [LB-1:0]        level_q  [MAX_JOBS];
	logic                 started_q[MAX_JOBS];
	logic [SB-1:0]        next_q   [MAX_JOBS];
	// List heads, tails, valid.
	logic [SB-1:0]        head_q [NQ];
	logic [SB-1:0]        tail_q [NQ];
	logic                 qv_q   [NQ];
	// Running job.
	logic                 run_v_q;
	logic [SB-1:0]        run_s_q;
	logic [SLB:0]         slice_q;
	logic [TICK_BITS-1:0] tick_q;
	logic [BOOST_BITS-1:0] bcnt_q;
	// Tick fields held for the whole tick.
	logic [15:0]          mask_q;
	logic                 ioreq_q;
	// Walk registers.
	logic                 io_busy_q;
	logic [SB-1:0]        io_cur_q, io_prev_q;
	logic                 io_hp_q;
	logic                 bo_busy_q;
	logic [LB-1:0]        bo_lv_q;
	logic [SB-1:0]        bo_cur_q;
	logic                 bo_walk_q;

	assign sts.io_busy = io_busy_q;
	assign sts.boost_busy = bo_busy_q;

	// Highest non-empty level for dispatch.
	logic          disp_hit;
	logic [LB-1:0] disp_lv;
	always_comb begin
		disp_hit = 1'b0;
		disp_lv = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (qv_q[i]) begin
				disp_hit = 1'b1;
				disp_lv = LB'(i);
			end
		end
	end

	// Current walk entry of the I/O list.
	logic          io_last, io_done;
	logic [SB-1:0] io_nxt;
	logic [LB-1:0] io_lvl;
	logic [QB-1:0] io_q;
	always_comb begin
		io_last = (io_cur_q == tail_q[IO_Q]);
		io_nxt = next_q[io_cur_q];
		io_done = ({1'b0, io_cur_q} < (SB+1)'(16)) && mask_q[4'(io_cur_q)];
		io_lvl = level_q[io_cur_q];
		io_q = QB'(io_lvl);
	end

	// Run step values.
	logic [SB-1:0]        rs;
	logic [LB-1:0]        rlv;
	logic [WORK_BITS-1:0] rem_n;
	logic [SLB:0]         slice_n;
	logic                 expire, can_demote;
	logic [LB-1:0]        new_lv;
	always_comb begin
		rs = run_s_q;
		rlv = level_q[rs];
		rem_n = (remain_q[rs] != '0) ? remain_q[rs] - 1'b1 : '0;
		slice_n = slice_q + 1'b1;
		expire = slice_n >= ((SLB+1)'(1) << rlv);
		can_demote = ({1'b0, rlv} + 1'b1) < (LB+1)'(NUM_LEVELS);
		new_lv = can_demote ? rlv + 1'b1 : rlv;
	end

	logic [BOOST_BITS-1:0] bcnt_n;
	assign bcnt_n = bcnt_q + 1'b1;

	// The boost walk is on its last level.
	logic bo_last_lv;
	assign bo_last_lv = ({1'b0, bo_lv_q} + 1'b1) >= (LB+1)'(NUM_LEVELS);

	always_ff @(posedge clk) begin
		// Arrival.
		if (cmd.arrive && ({{(SB){1'b0}}, job_id} < (SB+4)'(MAX_JOBS)) &&
			!(status_q[SB'(job_id)] == ST_READY || status_q[SB'(job_id)] == ST_RUN ||
			status_q[SB'(job_id)] == ST_WAIT)) begin
			remain_q[SB'(job_id)] <= work;
			level_q[SB'(job_id)] <= '0;
			started_q[SB'(job_id)] <= 1'b0;
			next_q[SB'(job_id)] <= '0;
			if (qv_q[0]) next_q[tail_q[0]] <= SB'(job_id);
		end
		// I/O walk step: unlink and push to own level.
		if (cmd.io_step && io_done) begin
			if (io_hp_q) next_q[io_prev_q] <= io_nxt;
			next_q[io_cur_q] <= '0;
			if (qv_q[io_q]) next_q[tail_q[io_q]] <= io_cur_q;
		end
		// Dispatch.
		if (cmd.dispatch && !run_v_q && disp_hit) begin
			started_q[head_q[disp_lv]] <= 1'b1;
		end
		// Run one unit.
		if (cmd.run && run_v_q) begin
			remain_q[rs] <= rem_n;
			if (rem_n != '0 && ioreq_q) begin
				next_q[rs] <= '0;
				if (qv_q[IO_Q]) next_q[tail_q[IO_Q]] <= rs;
			end else if (rem_n != '0 && expire) begin
				level_q[rs] <= new_lv;
				next_q[rs] <= '0;
				if (qv_q[QB'(new_lv)]) next_q[tail_q[QB'(new_lv)]] <= rs;
			end
		end
		// Boost: relevel one slot per cycle, link onto level 0 at the level's tail.
		if (cmd.boost_step && bo_walk_q) begin
			level_q[bo_cur_q] <= '0;
			if (bo_cur_q == tail_q[bo_lv_q] && qv_q[0]) next_q[tail_q[0]] <= head_q[bo_lv_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOBS; i++) status_q[i] <= ST_FREE;
			for (int q = 0; q < NQ; q++) begin
				qv_q[q] <= 1'b0;
				head_q[q] <= '0;
				tail_q[q] <= '0;
			end
			run_v_q <= 1'b0;
			run_s_q <= '0;
			slice_q <= '0;
			tick_q <= '0;
			bcnt_q <= '0;
			mask_q <= '0;
			ioreq_q <= 1'b0;
			io_busy_q <= 1'b0;
			io_cur_q <= '0;
			io_prev_q <= '0;
			io_hp_q <= 1'b0;
			bo_busy_q <= 1'b0;
			bo_lv_q <= '0;
			bo_cur_q <= '0;
			bo_walk_q <= 1'b0;
			r_tick <= '0;
			r_valid <= 1'b0;
			r_job <= '0;
			r_level <= '0;
			r_outcome <= OUT_NONE;
			r_first <= 1'b0;
			r_boost <= 1'b0;
			r_err <= 1'b0;
		end else begin
			// Arrival.
			if (cmd.arrive) begin
				r_tick <= tick_q;
				r_valid <= 1'b0;
				r_job <= '0;
				r_level <= '0;
				r_outcome <= OUT_NONE;
				r_first <= 1'b0;
				r_boost <= 1'b0;
				if (({{(SB){1'b0}}, job_id} >= (SB+4)'(MAX_JOBS)) ||
					status_q[SB'(job_id)] == ST_READY || status_q[SB'(job_id)] == ST_RUN ||
					status_q[SB'(job_id)] == ST_WAIT) begin
					r_err <= 1'b1;
				end else begin
					r_err <= 1'b0;
					status_q[SB'(job_id)] <= ST_READY;
					if (!qv_q[0]) head_q[0] <= SB'(job_id);
					tail_q[0] <= SB'(job_id);
					qv_q[0] <= 1'b1;
				end
			end
			// Tick start: hold the tick's fields for the later phases.
			if (cmd.io_start) begin
				r_tick <= tick_q;
				r_valid <= 1'b0;
				r_job <= '0;
				r_level <= '0;
				r_outcome <= OUT_NONE;
				r_first <= 1'b0;
				r_boost <= 1'b0;
				r_err <= 1'b0;
				mask_q <= io_done_mask;
				ioreq_q <= wants_io;
				io_busy_q <= qv_q[IO_Q];
				io_cur_q <= head_q[IO_Q];
				io_hp_q <= 1'b0;
			end
			// One I/O list entry per cycle.
			if (cmd.io_step) begin
				if (io_done) begin
					if (!io_hp_q) begin
						if (io_last) qv_q[IO_Q] <= 1'b0;
						else head_q[IO_Q] <= io_nxt;
					end else if (io_last) begin
						tail_q[IO_Q] <= io_prev_q;
					end
					status_q[io_cur_q] <= ST_READY;
					if (!qv_q[io_q]) head_q[io_q] <= io_cur_q;
					tail_q[io_q] <= io_cur_q;
					qv_q[io_q] <= 1'b1;
				end else begin
					io_prev_q <= io_cur_q;
					io_hp_q <= 1'b1;
				end
				io_cur_q <= io_nxt;
				if (io_last) io_busy_q <= 1'b0;
			end
			// Dispatch from highest non-empty level.
			if (cmd.dispatch && !run_v_q && disp_hit) begin
				run_v_q <= 1'b1;
				run_s_q <= head_q[disp_lv];
				status_q[head_q[disp_lv]] <= ST_RUN;
				slice_q <= '0;
				r_first <= !started_q[head_q[disp_lv]];
				if (head_q[disp_lv] == tail_q[disp_lv]) qv_q[disp_lv] <= 1'b0;
				else head_q[disp_lv] <= next_q[head_q[disp_lv]];
			end
			// Run one unit.
			if (cmd.run) begin
				if (run_v_q) begin
					r_valid <= 1'b1;
					r_job <= 4'(rs);
					r_level <= 2'(rlv);
					if (rem_n == '0) begin
						status_q[rs] <= ST_DONE;
						run_v_q <= 1'b0;
						slice_q <= '0;
						r_outcome <= OUT_FINISHED;
					end else if (ioreq_q) begin
						status_q[rs] <= ST_WAIT;
						if (!qv_q[IO_Q]) head_q[IO_Q] <= rs;
						tail_q[IO_Q] <= rs;
						qv_q[IO_Q] <= 1'b1;
						run_v_q <= 1'b0;
						slice_q <= '0;
						r_outcome <= OUT_TO_IO;
					end else if (expire) begin
						status_q[rs] <= ST_READY;
						if (!qv_q[QB'(new_lv)]) head_q[QB'(new_lv)] <= rs;
						tail_q[QB'(new_lv)] <= rs;
						qv_q[QB'(new_lv)] <= 1'b1;
						run_v_q <= 1'b0;
						slice_q <= '0;
						r_outcome <= OUT_EXPIRED;
					end else begin
						slice_q <= slice_n;
						r_outcome <= OUT_CONTINUE;
					end
				end
				tick_q <= tick_q + 1'b1;
			end
			// Boost decision.
			if (cmd.boost_start) begin
				if (bcnt_n >= boost_period) begin
					bcnt_q <= '0;
					r_boost <= 1'b1;
					bo_busy_q <= 1'b1;
					bo_lv_q <= LB'(1);
					bo_walk_q <= 1'b0;
				end else begin
					bcnt_q <= bcnt_n;
				end
			end
			// Boost: walk each lower level to relevel its jobs, splice it at its tail.
			if (cmd.boost_step) begin
				if (!bo_walk_q) begin
					if (qv_q[bo_lv_q]) begin
						bo_walk_q <= 1'b1;
						bo_cur_q <= head_q[bo_lv_q];
					end else if (bo_last_lv) begin
						bo_busy_q <= 1'b0;
					end else begin
						bo_lv_q <= bo_lv_q + 1'b1;
					end
				end else if (bo_cur_q == tail_q[bo_lv_q]) begin
					bo_walk_q <= 1'b0;
					if (!qv_q[0]) head_q[0] <= head_q[bo_lv_q];
					tail_q[0] <= tail_q[bo_lv_q];
					qv_q[0] <= 1'b1;
					qv_q[bo_lv_q] <= 1'b0;
					if (bo_last_lv) bo_busy_q <= 1'b0;
					else bo_lv_q <= bo_lv_q + 1'b1;
				end else begin
					bo_cur_q <= next_q[bo_cur_q];
				end
			end
		end
	end

	`MLFQ_ASSERT_IMP(a_no_overlap, clk, arst_n, io_busy_q, !bo_busy_q)
	`MLFQ_ASSERT_IMP(a_run_status, clk, arst_n, run_v_q && !cmd.run, status_q[run_s_q] == ST_RUN)
	`MLFQ_ASSERT_NXT(a_boost_flag, clk, arst_n, cmd.boost_start && (bcnt_n >= boost_period), r_boost)

endmodule

// ===== src/mlfq_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// mlfq_task_scheduler
// Three-level feedback queue scheduler over a sixteen-slot job table.
// ----------------------------------------------------------------------------
// Input channel: valid/stall; func 0 is an arrival, func 1 advances a tick.
// Output channel: valid/stall; one result item per input item.
// Configuration: cfg_valid/cfg_ready write the boost period; cfg_ready is
// high only while no item is in work.
// An arrival's result is valid in the cycle after it is accepted. A tick's
// result is valid after the I/O walk, dispatch, run and boost states; the
// I/O walk visits each entry of the I/O wait list and, on a boost, the boost
// walk visits each level from 1 up and each job queued in those levels.
// The list links are followed one entry per cycle.
// One item is in work at a time; in_stall is high from acceptance until the
// result is taken, and the next item can be accepted in the cycle after that.
// The result sits in output registers and holds while out_stall is high.
// Reset clears every slot to free, empties all lists, clears the tick and
// boost counters and sets the boost period to 20.
// ----------------------------------------------------------------------------
module mlfq_task_scheduler
	import mlfq_pkg::*;
#(
	parameter int MAX_JOBS = 16,
	parameter int NUM_LEVELS = 3,
	parameter int WORK_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [3:0]             job_id,
	input  logic [WORK_BITS-1:0]   work,
	input  logic [15:0]            io_done_mask,
	input  logic                   wants_io,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [TICK_BITS-1:0]   tick_count,
	output logic                   run_valid,
	output logic [3:0]             run_job,
	output logic [1:0]             run_level,
	output logic [2:0]             outcome,
	output logic                   first_run,
	output logic                   boosted,
	output logic                   arrival_error,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [BOOST_BITS-1:0]  cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic in_ready;
	logic in_fire;
	logic res_valid;
	logic [BOOST_BITS-1:0] interval_q;

	assign in_stall = !in_ready;
	assign in_fire = in_valid && in_ready;
	assign cfg_ready = in_ready;
	assign out_valid = res_valid;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= BOOST_BITS'(20);
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	mlfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_func   (func),
		.out_free  (res_valid && !out_stall),
		.sts       (sts),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.cmd       (cmd)
	);

	mlfq_dp #(
		.MAX_JOBS   (MAX_JOBS),
		.NUM_LEVELS (NUM_LEVELS),
		.WORK_BITS  (WORK_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.job_id         (job_id),
		.work           (work),
		.io_done_mask   (io_done_mask),
		.wants_io       (wants_io),
		.boost_period   (interval_q),
		.sts            (sts),
		.r_tick         (tick_count),
		.r_valid        (run_valid),
		.r_job          (run_job),
		.r_level        (run_level),
		.r_outcome      (outcome),
		.r_first        (first_run),
		.r_boost        (boosted),
		.r_err          (arrival_error)
	);

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Feedback queue scheduler testbench
// Drives arrival and tick items into the scheduler, predicts every result
// item with an independent model of the job table and its lists, and checks
// each result field by field under several boost intervals and idling modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import mlfq_pkg::*;

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;
	localparam int   JOBS        = 16;
	localparam int   LEVELS      = 3;
	localparam int   IO_Q        = LEVELS;
	localparam int   CYCLE_LIMIT = 1000000;
	localparam int   RAND_ITEMS  = 240;

	typedef struct packed {
		logic [TICK_BITS-1:0] tick;
		logic                 rv;
		logic [3:0]           job;
		logic [1:0]           lvl;
		logic [2:0]           outc;
		logic                 first;
		logic                 boost;
		logic                 err;
	} sched_result_t;

	// Scheduler model and the queue of results it predicts.
	class sched_scoreboard;
		logic [2:0]            status [JOBS];
		logic [15:0]           remaining [JOBS];
		logic [1:0]            level [JOBS];
		logic                  started [JOBS];
		logic [3:0]            link [JOBS];
		logic [3:0]            q_head [LEVELS+1];
		logic [3:0]            q_tail [LEVELS+1];
		logic                  q_valid [LEVELS+1];
		logic                  cur_valid;
		logic [3:0]            cur_slot;
		int unsigned           slice;
		logic [TICK_BITS-1:0]  ticks;
		logic [BOOST_BITS-1:0] since_boost;
		logic [BOOST_BITS-1:0] interval;
		sched_result_t         pending_results [$];
		int                    errors;

		function new();
			for (int i = 0; i < JOBS; i++) begin
				status[i] = ST_FREE;
				remaining[i] = '0;
				level[i] = '0;
				started[i] = 1'b0;
				link[i] = '0;
			end
			for (int q = 0; q <= LEVELS; q++) begin
				q_head[q] = '0;
				q_tail[q] = '0;
				q_valid[q] = 1'b0;
			end
			cur_valid = 1'b0;
			cur_slot = '0;
			slice = 0;
			ticks = '0;
			since_boost = '0;
			interval = 16'd20;
			errors = 0;
		endfunction

		function void enqueue(int q, logic [3:0] s);
			link[s] = '0;
			if (q_valid[q]) begin
				link[q_tail[q]] = s;
				q_tail[q] = s;
			end else begin
				q_head[q] = s;
				q_tail[q] = s;
				q_valid[q] = 1'b1;
			end
		endfunction

		function logic [3:0] dequeue(int q);
			logic [3:0] s;
			s = q_head[q];
			if (s == q_tail[q])
				q_valid[q] = 1'b0;
			else
				q_head[q] = link[s];
			return s;
		endfunction

		// Jobs whose I/O completes go back to their level in wait-list order.
		function void release_io(logic [15:0] mask);
			logic       have_prev;
			logic [3:0] prev;
			logic [3:0] cur;
			logic [3:0] nxt;
			logic       last;
			have_prev = 1'b0;
			prev = '0;
			if (!q_valid[IO_Q])
				return;
			cur = q_head[IO_Q];
			for (int n = 0; n < JOBS; n++) begin
				last = (cur == q_tail[IO_Q]);
				nxt = link[cur];
				if (mask[cur]) begin
					if (!have_prev) begin
						if (last)
							q_valid[IO_Q] = 1'b0;
						else
							q_head[IO_Q] = nxt;
					end else begin
						link[prev] = nxt;
						if (last)
							q_tail[IO_Q] = prev;
					end
					status[cur] = ST_READY;
					enqueue(level[cur], cur);
				end else begin
					prev = cur;
					have_prev = 1'b1;
				end
				if (last)
					break;
				cur = nxt;
			end
		endfunction

		// Splice the lower levels onto level 0 and reset their level.
		function void boost_all();
			logic [3:0] s;
			for (int lv = 1; lv < LEVELS; lv++) begin
				if (!q_valid[lv])
					continue;
				s = q_head[lv];
				for (int n = 0; n < JOBS; n++) begin
					level[s] = '0;
					if (s == q_tail[lv])
						break;
					s = link[s];
				end
				if (q_valid[0]) begin
					link[q_tail[0]] = q_head[lv];
					q_tail[0] = q_tail[lv];
				end else begin
					q_head[0] = q_head[lv];
					q_tail[0] = q_tail[lv];
					q_valid[0] = 1'b1;
				end
				q_valid[lv] = 1'b0;
			end
		endfunction

		// Advance the model by one accepted input item.
		function void note_item(logic f, logic [3:0] id, logic [15:0] w, logic [15:0] mask,
				logic ioreq);
			sched_result_t r;
			int            lv;
			r = '0;
			r.tick = ticks;
			if (f == FUNC_ARRIVE) begin
				if (status[id] == ST_READY || status[id] == ST_RUN ||
						status[id] == ST_WAIT) begin
					r.err = 1'b1;
				end else begin
					status[id] = ST_READY;
					remaining[id] = w;
					level[id] = '0;
					started[id] = 1'b0;
					enqueue(0, id);
				end
			end else begin
				release_io(mask);
				if (!cur_valid) begin
					for (int q = 0; q < LEVELS; q++) begin
						if (q_valid[q]) begin
							cur_slot = dequeue(q);
							cur_valid = 1'b1;
							status[cur_slot] = ST_RUN;
							slice = 0;
							if (!started[cur_slot]) begin
								started[cur_slot] = 1'b1;
								r.first = 1'b1;
							end
							break;
						end
					end
				end
				if (cur_valid) begin
					lv = level[cur_slot];
					r.rv = 1'b1;
					r.job = cur_slot;
					r.lvl = lv;
					if (remaining[cur_slot] != 0)
						remaining[cur_slot]--;
					slice++;
					if (remaining[cur_slot] == 0) begin
						status[cur_slot] = ST_DONE;
						cur_valid = 1'b0;
						slice = 0;
						r.outc = OUT_FINISHED;
					end else if (ioreq) begin
						status[cur_slot] = ST_WAIT;
						enqueue(IO_Q, cur_slot);
						cur_valid = 1'b0;
						slice = 0;
						r.outc = OUT_TO_IO;
					end else if (slice >= (1 << lv)) begin
						if (lv + 1 < LEVELS)
							level[cur_slot] = lv + 1;
						status[cur_slot] = ST_READY;
						enqueue(level[cur_slot], cur_slot);
						cur_valid = 1'b0;
						slice = 0;
						r.outc = OUT_EXPIRED;
					end else begin
						r.outc = OUT_CONTINUE;
					end
				end
				since_boost = since_boost + 1'b1;
				if (since_boost >= interval) begin
					boost_all();
					since_boost = '0;
					r.boost = 1'b1;
				end
				ticks = ticks + 1'b1;
			end
			pending_results.push_back(r);
		endfunction

		function void compare(string name, longint unsigned e, longint unsigned a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t e;
			if (pending_results.size() == 0) begin
				$error("result item with no expectation waiting");
				errors++;
				return;
			end
			e = pending_results.pop_front();
			compare("tick_count", e.tick, got.tick);
			compare("run_valid", e.rv, got.rv);
			compare("run_job", e.job, got.job);
			compare("run_level", e.lvl, got.lvl);
			compare("outcome", e.outc, got.outc);
			compare("first_run", e.first, got.first);
			compare("boosted", e.boost, got.boost);
			compare("arrival_error", e.err, got.err);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  func;
	logic [3:0]            job_id;
	logic [15:0]           work;
	logic [15:0]           io_done_mask;
	logic                  wants_io;
	logic                  out_valid;
	logic                  out_stall;
	logic [TICK_BITS-1:0]  tick_count;
	logic                  run_valid;
	logic [3:0]            run_job;
	logic [1:0]            run_level;
	logic [2:0]            outcome;
	logic                  first_run;
	logic                  boosted;
	logic                  arrival_error;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [BOOST_BITS-1:0] cfg_data;

	sched_scoreboard sb;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              cycles;

	mlfq_task_scheduler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.job_id       (job_id),
		.work         (work),
		.io_done_mask (io_done_mask),
		.wants_io     (wants_io),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tick_count   (tick_count),
		.run_valid    (run_valid),
		.run_job      (run_job),
		.run_level    (run_level),
		.outcome      (outcome),
		.first_run    (first_run),
		.boosted      (boosted),
		.arrival_error(arrival_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Take result items and stall the output at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({tick_count, run_valid, run_job, run_level, outcome,
				first_run, boosted, arrival_error});
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one input item after an optional random gap.
	task automatic send_item(logic f, logic [3:0] id, logic [15:0] w, logic [15:0] mask,
			logic ioreq);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		job_id <= id;
		work <= w;
		io_done_mask <= mask;
		wants_io <= ioreq;
		do @(posedge clk); while (in_stall);
		sb.note_item(f, id, w, mask, ioreq);
	endtask

	// Let every expected result drain, then write boost_period.
	task automatic write_interval(logic [BOOST_BITS-1:0] value);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.interval = value;
	endtask

	function automatic logic [15:0] pick_work();
		int p;
		p = $urandom_range(99);
		if (p < 70)
			return $urandom_range(6, 1);
		else if (p < 90)
			return $urandom_range(40, 7);
		else if (p < 95)
			return 16'd0;
		else
			return $urandom;
	endfunction

	function automatic logic [15:0] pick_mask();
		if ($urandom_range(3) == 0)
			return $urandom;
		return 16'(1 << $urandom_range(15)) | 16'(1 << $urandom_range(15));
	endfunction

	// Random mix of arrivals and ticks, about 30 percent arrivals.
	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 30)
				send_item(FUNC_ARRIVE, $urandom_range(15), pick_work(), $urandom, $urandom);
			else
				send_item(FUNC_TICK, $urandom, $urandom, pick_mask(),
					($urandom_range(99) < 20));
		end
	endtask

	initial begin
		logic [BOOST_BITS-1:0] intervals [6];
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_ARRIVE;
		job_id <= '0;
		work <= '0;
		io_done_mask <= '0;
		wants_io <= 1'b0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset interval: extremes, busy slot, zero work, I/O.
		send_item(FUNC_ARRIVE, 4'd0, 16'd0, 16'h0000, 1'b0);
		send_item(FUNC_ARRIVE, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(FUNC_ARRIVE, 4'd0, 16'd3, 16'h0000, 1'b0);
		send_item(FUNC_ARRIVE, 4'd1, 16'd1, 16'h0000, 1'b0);
		send_item(FUNC_ARRIVE, 4'd2, 16'd9, 16'h0000, 1'b0);
		send_item(FUNC_TICK, 4'd0, 16'd0, 16'h0000, 1'b0);
		send_item(FUNC_ARRIVE, 4'd0, 16'd5, 16'h0000, 1'b0);
		send_item(FUNC_TICK, 4'd15, 16'hFFFF, 16'h0000, 1'b0);
		send_item(FUNC_TICK, 4'd0, 16'd0, 16'h0000, 1'b1);
		send_item(FUNC_ARRIVE, 4'd15, 16'd2, 16'h0000, 1'b0);
		send_item(FUNC_TICK, 4'd0, 16'd0, 16'h0000, 1'b0);
		send_item(FUNC_TICK, 4'd0, 16'd0, 16'h0000, 1'b1);
		send_item(FUNC_TICK, 4'd0, 16'd0, 16'h0001, 1'b0);
		send_item(FUNC_TICK, 4'd0, 16'd0, 16'hFFFF, 1'b0);
		for (int i = 0; i < 10; i++)
			send_item(FUNC_TICK, 4'd0, 16'd0, 16'h0000, 1'b0);

		// Random phases over several intervals and idling modes.
		intervals = '{16'd20, 16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd7};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0)
				write_interval(intervals[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			random_phase(RAND_ITEMS);
		end

		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
